FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/slrb_pkg.sv
package slrb_pkg;

  localparam int LAYER_COUNT = 4;
  localparam int BYTE_COUNT  = 4;
  localparam int CFG_IDX_W   = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd4;

  // Pixel format codes
  localparam logic [3:0] FMT_RGBA = 4'd0;
  localparam logic [3:0] FMT_BGRA = 4'd1;
  localparam logic [3:0] FMT_ARGB = 4'd2;
  localparam logic [3:0] FMT_ABGR = 4'd3;
  localparam logic [3:0] FMT_RGBX = 4'd4;
  localparam logic [3:0] FMT_BGRX = 4'd5;
  localparam logic [3:0] FMT_XRGB = 4'd6;
  localparam logic [3:0] FMT_XBGR = 4'd7;
  localparam logic [3:0] FMT_RGB  = 4'd8;
  localparam logic [3:0] FMT_BGR  = 4'd9;

  typedef enum logic [2:0] {
    CH_RED, CH_GREEN, CH_BLUE, CH_ALPHA, CH_INV_ALPHA, CH_ZERO
  } chan_sel_t;

  typedef logic [7:0] byte_t;

  // Which layer channel lands in a given destination byte
  function automatic chan_sel_t fmt_sel(input logic [3:0] fmt, input logic [1:0] pos);
    chan_sel_t sel;
    sel = CH_ZERO;
    case (fmt)
      FMT_RGBA: case (pos)
        2'd0: sel = CH_RED;  2'd1: sel = CH_GREEN; 2'd2: sel = CH_BLUE;
        default: sel = CH_INV_ALPHA;
      endcase
      FMT_BGRA: case (pos)
        2'd0: sel = CH_BLUE; 2'd1: sel = CH_GREEN; 2'd2: sel = CH_RED;
        default: sel = CH_INV_ALPHA;
      endcase
      FMT_ARGB: case (pos)
        2'd0: sel = CH_INV_ALPHA; 2'd1: sel = CH_RED; 2'd2: sel = CH_GREEN;
        default: sel = CH_BLUE;
      endcase
      FMT_ABGR: case (pos)
        2'd0: sel = CH_INV_ALPHA; 2'd1: sel = CH_BLUE; 2'd2: sel = CH_GREEN;
        default: sel = CH_RED;
      endcase
      FMT_RGBX: case (pos)
        2'd0: sel = CH_RED;  2'd1: sel = CH_GREEN; 2'd2: sel = CH_BLUE;
        default: sel = CH_ALPHA;
      endcase
      FMT_BGRX: case (pos)
        2'd0: sel = CH_BLUE; 2'd1: sel = CH_GREEN; 2'd2: sel = CH_RED;
        default: sel = CH_ALPHA;
      endcase
      FMT_XRGB: case (pos)
        2'd0: sel = CH_ALPHA; 2'd1: sel = CH_RED; 2'd2: sel = CH_GREEN;
        default: sel = CH_BLUE;
      endcase
      FMT_XBGR: case (pos)
        2'd0: sel = CH_ALPHA; 2'd1: sel = CH_BLUE; 2'd2: sel = CH_GREEN;
        default: sel = CH_RED;
      endcase
      FMT_RGB: case (pos)
        2'd0: sel = CH_RED;  2'd1: sel = CH_GREEN; 2'd2: sel = CH_BLUE;
        default: sel = CH_ZERO;
      endcase
      FMT_BGR: case (pos)
        2'd0: sel = CH_BLUE; 2'd1: sel = CH_GREEN; 2'd2: sel = CH_RED;
        default: sel = CH_ZERO;
      endcase
      default: sel = CH_ZERO;
    endcase
    return sel;
  endfunction

  // Pick one byte out of a packed layer colour
  function automatic byte_t channel_of(input logic [31:0] colour, input chan_sel_t sel);
    byte_t val;
    case (sel)
      CH_RED:       val = colour[31:24];
      CH_GREEN:     val = colour[23:16];
      CH_BLUE:      val = colour[15:8];
      CH_ALPHA:     val = colour[7:0];
      CH_INV_ALPHA: val = 8'd255 - colour[7:0];
      default:      val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: src/subtitle_layer_rgb_blend_core.sv
// Channel   Handshake                 Payload
// pixel     pixel_valid/pixel_stall   coverage0..3, dest_byte0..3
// result    result_valid/result_stall out_byte0..3
// config    cfg_write                 cfg_index, cfg_data
//
// One pixel per cycle sustained while result_stall is low; the result is
// carried through the clamp, scale, product and sum registers. Synchronous
// reset clears the stage valid bits and layer colours and selects RGBA.
// Each stage holds only while the one after it is full and held, so bubbles
// collapse and a stalled result does not block pixels behind it until full.
`include "assert_macros.svh"

module subtitle_layer_rgb_blend_core
  import slrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  logic [7:0]           coverage0,
  input  logic [7:0]           coverage1,
  input  logic [7:0]           coverage2,
  input  logic [7:0]           coverage3,
  input  logic [7:0]           dest_byte0,
  input  logic [7:0]           dest_byte1,
  input  logic [7:0]           dest_byte2,
  input  logic [7:0]           dest_byte3,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [7:0]           out_byte0,
  output logic [7:0]           out_byte1,
  output logic [7:0]           out_byte2,
  output logic [7:0]           out_byte3
);

  logic [31:0] layer_colour [LAYER_COUNT];
  logic [3:0]  pixel_format;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LAYER_COUNT; l++) layer_colour[l] <= '0;
      pixel_format <= FMT_RGBA;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LAYER0: layer_colour[0] <= cfg_data;
        REG_LAYER1: layer_colour[1] <= cfg_data;
        REG_LAYER2: layer_colour[2] <= cfg_data;
        REG_LAYER3: layer_colour[3] <= cfg_data;
        REG_FORMAT: pixel_format    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic fmt_scaled, fmt_three, fmt_unused;
  assign fmt_scaled = (pixel_format >= FMT_RGBX);
  assign fmt_three  = (pixel_format == FMT_RGB) || (pixel_format == FMT_BGR);
  assign fmt_unused = (pixel_format > FMT_BGR);

  // Stage enables: a stage moves when it is empty or the next one moves
  logic s1_valid, s2_valid, s3_valid;
  logic en1, en2, en3, en4;
  assign en4 = !result_valid || !result_stall;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign pixel_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) s1_valid     <= pixel_valid;
      if (en2) s2_valid     <= s1_valid;
      if (en3) s3_valid     <= s2_valid;
      if (en4) result_valid <= s3_valid;
    end
  end

  // Stage 1: clamp coverages in layer order, look up channel bytes
  byte_t cov_in  [LAYER_COUNT];
  byte_t dst_in  [BYTE_COUNT];
  byte_t k_clamp [LAYER_COUNT];
  byte_t chan_now [BYTE_COUNT][LAYER_COUNT];

  assign cov_in[0] = coverage0;
  assign cov_in[1] = coverage1;
  assign cov_in[2] = coverage2;
  assign cov_in[3] = coverage3;
  assign dst_in[0] = dest_byte0;
  assign dst_in[1] = dest_byte1;
  assign dst_in[2] = dest_byte2;
  assign dst_in[3] = dest_byte3;

  always_comb begin
    byte_t accum;
    byte_t room;
    accum = 8'd0;
    for (int l = 0; l < LAYER_COUNT; l++) begin
      room = 8'd255 - accum;
      k_clamp[l] = (cov_in[l] > room) ? room : cov_in[l];
      accum = accum + k_clamp[l];
    end
    for (int c = 0; c < BYTE_COUNT; c++) begin
      for (int l = 0; l < LAYER_COUNT; l++) begin
        chan_now[c][l] = channel_of(layer_colour[l], fmt_sel(pixel_format, 2'(c)));
      end
    end
  end

  byte_t s1_k    [LAYER_COUNT];
  byte_t s1_chan [BYTE_COUNT][LAYER_COUNT];
  byte_t s1_dst  [BYTE_COUNT];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_k    <= k_clamp;
      s1_chan <= chan_now;
      s1_dst  <= dst_in;
    end
  end

  // Stage 2: scale coverage by layer transparency where the format asks
  byte_t k_scaled [LAYER_COUNT];
  always_comb begin
    logic [16:0] prod;
    for (int l = 0; l < LAYER_COUNT; l++) begin
      prod = {9'd0, s1_k[l]} * (17'd256 - {9'd0, layer_colour[l][7:0]});
      k_scaled[l] = fmt_scaled ? prod[15:8] : s1_k[l];
    end
  end

  byte_t s2_k    [LAYER_COUNT];
  byte_t s2_chan [BYTE_COUNT][LAYER_COUNT];
  byte_t s2_dst  [BYTE_COUNT];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_k    <= k_scaled;
      s2_chan <= s1_chan;
      s2_dst  <= s1_dst;
    end
  end

  // Stage 3: layer products and total coverage
  logic [15:0] prod_now [BYTE_COUNT][LAYER_COUNT];
  logic [9:0]  total_now;
  always_comb begin
    total_now = 10'd0;
    for (int l = 0; l < LAYER_COUNT; l++) begin
      total_now = total_now + {2'd0, s2_k[l]};
    end
    for (int c = 0; c < BYTE_COUNT; c++) begin
      for (int l = 0; l < LAYER_COUNT; l++) begin
        prod_now[c][l] = {8'd0, s2_k[l]} * {8'd0, s2_chan[c][l]};
      end
    end
  end

  logic [15:0] s3_prod [BYTE_COUNT][LAYER_COUNT];
  logic [9:0]  s3_total;
  byte_t       s3_dst  [BYTE_COUNT];

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_prod  <= prod_now;
      s3_total <= total_now;
      s3_dst   <= s2_dst;
    end
  end

  // Stage 4: weight destination, sum, take the high byte; unused formats and RGB/BGR byte 3 pass dest
  byte_t blend_now [BYTE_COUNT];
  always_comb begin
    logic [17:0] acc;
    logic [9:0]  inv_total;
    inv_total = 10'd256 - s3_total;
    for (int c = 0; c < BYTE_COUNT; c++) begin
      acc = {10'd0, s3_dst[c]} * {8'd0, inv_total};
      for (int l = 0; l < LAYER_COUNT; l++) begin
        acc = acc + {2'd0, s3_prod[c][l]};
      end
      if (fmt_unused || (fmt_three && c == BYTE_COUNT - 1)) begin
        blend_now[c] = s3_dst[c];
      end else begin
        blend_now[c] = acc[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_byte0 <= blend_now[0];
      out_byte1 <= blend_now[1];
      out_byte2 <= blend_now[2];
      out_byte3 <= blend_now[3];
    end
  end

  // Checks
  logic [9:0] s1_k_sum;
  assign s1_k_sum = {2'd0, s1_k[0]} + {2'd0, s1_k[1]} + {2'd0, s1_k[2]} + {2'd0, s1_k[3]};

  `ASSERT_SAME(a_clamp_sum, clk, rst, s1_valid, s1_k_sum <= 10'd255, "clamped coverage over 255")
  `ASSERT_SAME(a_empty_no_stall, clk, rst, !result_valid, !pixel_stall, "stall with empty output")
  `ASSERT_SAME(a_full_stall, clk, rst,
    s1_valid && s2_valid && s3_valid && result_valid && result_stall, pixel_stall,
    "full pipe took a pixel")
  `ASSERT_NEXT(a_reset_clear, clk, rst, !result_valid && !s1_valid, "valid after reset")

endmodule

FILE: bench/tb.sv
module tb;
  import slrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [BYTE_COUNT-1:0][7:0] quad_t;

  localparam logic [3:0] FMT_UNUSED_LO = 4'd10;
  localparam logic [3:0] FMT_UNUSED_HI = 4'd15;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_FORMAT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [11:0][3:0] DIRECTED_FMTS = {
    FMT_UNUSED_HI, FMT_UNUSED_LO, FMT_BGR, FMT_RGB, FMT_XBGR, FMT_XRGB,
    FMT_BGRX, FMT_RGBX, FMT_ABGR, FMT_ARGB, FMT_BGRA, FMT_RGBA
  };
  localparam int IDLE_PCT       = 29;
  localparam int HOLD_OFF_LEN   = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 12;

  logic       clk;
  logic       rst          = 1'b1;
  logic       cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data    = '0;
  logic       pixel_valid  = 1'b0;
  logic       pixel_stall;
  logic [7:0] coverage0    = '0;
  logic [7:0] coverage1    = '0;
  logic [7:0] coverage2    = '0;
  logic [7:0] coverage3    = '0;
  logic [7:0] dest_byte0   = '0;
  logic [7:0] dest_byte1   = '0;
  logic [7:0] dest_byte2   = '0;
  logic [7:0] dest_byte3   = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;

  // Shadow of the block's registers
  logic [31:0] layer_rgba [LAYER_COUNT];
  logic [3:0]  pix_fmt;

  quad_t blended_q [$];
  int    pixels_sent   = 0;
  int    results_seen  = 0;
  int    bad_results   = 0;
  int    settings_used = 0;
  int    hold_req      = 0;
  bit    steady_run    = 1'b0;
  int    quiet_cycles  = 0;

  subtitle_layer_rgb_blend_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .coverage0    (coverage0),
    .coverage1    (coverage1),
    .coverage2    (coverage2),
    .coverage3    (coverage3),
    .dest_byte0   (dest_byte0),
    .dest_byte1   (dest_byte1),
    .dest_byte2   (dest_byte2),
    .dest_byte3   (dest_byte3),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte0    (out_byte0),
    .out_byte1    (out_byte1),
    .out_byte2    (out_byte2),
    .out_byte3    (out_byte3)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int i;
    for (i = 0; i < LAYER_COUNT; i++) layer_rgba[i] = '0;
    pix_fmt = FMT_RGBA;
  end

  // Layer byte that lands in destination byte pos for this format
  function automatic logic [7:0] format_lane(input logic [31:0] colour, input logic [3:0] fmt,
                                             input int pos);
    logic [3:0][7:0] lanes;
    logic [7:0] r, g, b, a;
    r = colour[31:24];
    g = colour[23:16];
    b = colour[15:8];
    a = colour[7:0];
    // lanes listed byte3 down to byte0
    case (fmt)
      FMT_RGBA: lanes = {~a, b, g, r};
      FMT_BGRA: lanes = {~a, r, g, b};
      FMT_ARGB: lanes = {b, g, r, ~a};
      FMT_ABGR: lanes = {r, g, b, ~a};
      FMT_RGBX: lanes = {a, b, g, r};
      FMT_BGRX: lanes = {a, r, g, b};
      FMT_XRGB: lanes = {b, g, r, a};
      FMT_XBGR: lanes = {r, g, b, a};
      FMT_RGB:  lanes = {8'h00, b, g, r};
      FMT_BGR:  lanes = {8'h00, r, g, b};
      default:  lanes = '0;
    endcase
    return lanes[pos[1:0]];
  endfunction

  // Blend the four layers into one destination pixel
  function automatic quad_t blend_pixel(input quad_t cov, input quad_t dst);
    quad_t       res;
    int unsigned acc, total, k, v;
    int unsigned weight [LAYER_COUNT];
    int          lay, c, nbytes;
    bit          scaled;
    res = dst;
    if (pix_fmt > FMT_BGR) return res;
    scaled = (pix_fmt >= FMT_RGBX);
    nbytes = (pix_fmt >= FMT_RGB) ? 3 : BYTE_COUNT;
    acc = 0;
    total = 0;
    // clamp in priority order, then scale by layer alpha where needed
    for (lay = 0; lay < LAYER_COUNT; lay++) begin
      k = 32'(cov[lay]);
      if (k > 255 - acc) begin
        k = 255 - acc;
        acc = 255;
      end else begin
        acc += k;
      end
      if (scaled) k = (k * (256 - layer_rgba[lay][7:0])) >> 8;
      weight[lay] = k;
      total += k;
    end
    for (c = 0; c < nbytes; c++) begin
      v = dst[c] * (256 - total);
      for (lay = 0; lay < LAYER_COUNT; lay++)
        v += weight[lay] * format_lane(layer_rgba[lay], pix_fmt, c);
      res[c] = v[15:8];
    end
    return res;
  endfunction

  // Write one register; leaves cfg_write high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < LAYER_COUNT) layer_rgba[idx] = data;
    else if (idx == REG_FORMAT) pix_fmt = data[3:0];
  endtask

  task automatic apply_setting(input logic [LAYER_COUNT-1:0][31:0] colours,
                               input logic [31:0] fmt_word);
    int i;
    for (i = 0; i < LAYER_COUNT; i++)
      write_reg(REG_LAYER0 + CFG_IDX_W'(i), colours[i]);
    write_reg(REG_FORMAT, fmt_word);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Offer one beat and hold it until accepted
  task automatic send_pixel(input quad_t cov, input quad_t dst);
    while (!steady_run && ($urandom_range(0, 99) < IDLE_PCT)) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    coverage0  <= cov[0];
    coverage1  <= cov[1];
    coverage2  <= cov[2];
    coverage3  <= cov[3];
    dest_byte0 <= dst[0];
    dest_byte1 <= dst[1];
    dest_byte2 <= dst[2];
    dest_byte3 <= dst[3];
    do @(posedge clk); while (pixel_stall);
    blended_q.push_back(blend_pixel(cov, dst));
    pixels_sent++;
  endtask

  // Stop offering and hold until every blended pixel is back
  task automatic wait_drain();
    pixel_valid <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_colour();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 7))
      0: c = 32'h0000_0000;
      1: c = 32'hFFFF_FFFF;
      2: c[7:0] = 8'hFF;
      3: c[7:0] = 8'h00;
      default: ;
    endcase
    return c;
  endfunction

  task automatic rand_pixel(output quad_t cov, output quad_t dst);
    int i;
    dst = $urandom;
    case ($urandom_range(0, 9))
      0: dst = '0;
      1: dst = '1;
      default: ;
    endcase
    for (i = 0; i < LAYER_COUNT; i++) begin
      case ($urandom_range(0, 9))
        0:       cov[i] = 8'd0;
        1:       cov[i] = 8'd255;
        2, 3:    cov[i] = 8'($urandom_range(0, 70));
        4, 5, 6: cov[i] = 8'($urandom_range(60, 200));
        default: cov[i] = 8'($urandom);
      endcase
    end
  endtask

  task automatic rand_setting();
    logic [LAYER_COUNT-1:0][31:0] colours;
    logic [31:0] fmt_word;
    int i;
    for (i = 0; i < LAYER_COUNT; i++) colours[i] = rand_colour();
    fmt_word = $urandom;
    if ($urandom_range(0, 9) == 0)
      fmt_word[3:0] = 4'($urandom_range(FMT_UNUSED_LO, FMT_UNUSED_HI));
    else fmt_word[3:0] = 4'($urandom_range(FMT_RGBA, FMT_BGR));
    // spare indexes must not disturb anything
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    apply_setting(colours, fmt_word);
  endtask

  // Pixels with the reset settings
  task automatic test_reset_defaults();
    send_pixel({8'd0, 8'd0, 8'd0, 8'd255}, {8'h11, 8'h22, 8'h33, 8'h44});
    send_pixel({8'd90, 8'd90, 8'd90, 8'd90}, {8'hFF, 8'h00, 8'hFF, 8'h00});
    wait_drain();
  endtask

  // Every format with extreme colours, clamp and saturation corners
  task automatic test_directed_formats();
    logic [LAYER_COUNT-1:0][31:0] colours;
    quad_t cov, dst;
    int f, k;
    for (f = 0; f < 12; f++) begin
      if (f % 2 == 0) colours = {32'hA5C3_E1FF, 32'h1234_5680, 32'h0000_0000, 32'hFFFF_FFFF};
      else colours = {32'hFFFF_FF00, 32'h00FF_00FF, 32'hFFFF_FFFF, 32'h80FF_4000};
      apply_setting(colours, {28'h0, DIRECTED_FMTS[f]});
      for (k = 0; k < 2; k++) begin
        case ((2 * f + k) % 4)
          0: begin
            cov = {8'd255, 8'd255, 8'd255, 8'd255};
            dst = {8'hFF, 8'h00, 8'hFF, 8'h00};
          end
          1: begin
            cov = '0;
            dst = {8'h7F, 8'h80, 8'h00, 8'hFF};
          end
          2: begin
            cov = {8'd7, 8'd255, 8'd100, 8'd200};
            dst = {8'hFF, 8'hFF, 8'h00, 8'h00};
          end
          default: begin
            cov = {8'd0, 8'd85, 8'd85, 8'd85};
            dst = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
          end
        endcase
        send_pixel(cov, dst);
      end
      wait_drain();
    end
  endtask

  // Writes to unused indexes leave the settings alone
  task automatic test_spare_indexes();
    quad_t cov, dst;
    int r;
    int i;
    apply_setting({32'h3C5A_7E10, 32'hC0FF_EE40, 32'h0F1E_2D3C, 32'hFEDC_BA98},
                  {28'hFFF_FFFF, FMT_XRGB});
    for (r = int'(REG_SPARE_LO); r <= int'(REG_SPARE_HI); r++)
      write_reg(CFG_IDX_W'(r), $urandom);
    cfg_write <= 1'b0;
    for (i = 0; i < 3; i++) begin
      rand_pixel(cov, dst);
      send_pixel(cov, dst);
    end
    wait_drain();
  endtask

  // Random settings, random pixels per phase
  task automatic test_random_phases();
    quad_t cov, dst;
    int phase, i;
    for (phase = 0; phase < 9; phase++) begin
      rand_setting();
      for (i = 0; i < 50; i++) begin
        rand_pixel(cov, dst);
        send_pixel(cov, dst);
      end
      wait_drain();
    end
  endtask

  // Fill the pipe against a held-off receiver, then run flat out
  task automatic test_backpressure();
    quad_t cov, dst;
    int i;
    rand_setting();
    steady_run = 1'b1;
    hold_req = HOLD_OFF_LEN;
    for (i = 0; i < 40; i++) begin
      rand_pixel(cov, dst);
      send_pixel(cov, dst);
    end
    wait_drain();
    rand_setting();
    for (i = 0; i < 60; i++) begin
      rand_pixel(cov, dst);
      send_pixel(cov, dst);
    end
    wait_drain();
    steady_run = 1'b0;
  endtask

  // Result side stall: random, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Compare each accepted result beat with the oldest blended pixel
  always @(posedge clk) begin : check_result
    quad_t got, want;
    bit    bad;
    int    b;
    if (!rst && result_valid && !result_stall) begin
      got = {out_byte3, out_byte2, out_byte1, out_byte0};
      results_seen++;
      if (blended_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected result beat %08h", got);
      end else begin
        want = blended_q.pop_front();
        bad = 1'b0;
        for (b = 0; b < BYTE_COUNT; b++)
          if (got[b] !== want[b]) bad = 1'b1;
        if (bad) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result %0d mismatch: expected %08h got %08h (byte3..byte0)",
                     results_seen, want, got);
        end
      end
    end
  end

  // End the run if neither channel moves for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("subtitle_layer_rgb_blend_core regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_formats();
    test_spare_indexes();
    test_random_phases();
    test_backpressure();
    // let any stray beat surface
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (blended_q.size() != 0) begin
      $display("%0d blended pixels never came back", blended_q.size());
      bad_results += blended_q.size();
    end
    $display("sent %0d pixels, checked %0d results over %0d register settings,",
             pixels_sent, results_seen, settings_used);
    $display("all ten formats, unused codes and indexes, random and held-off stalls");
    if (bad_results == 0) begin
      $display("subtitle_layer_rgb_blend_core regression: pass");
    end else begin
      $display("%0d bad results", bad_results);
      $display("subtitle_layer_rgb_blend_core regression: fail");
    end
    $finish;
  end

endmodule
